// ===== src/mcr_pkg.sv =====
package mcr_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_FRAME_DIM = 4096;

    localparam int DIM_W   = 13;
    localparam int PIX_W   = 12;
    localparam int ADDR_W  = 24;
    localparam int COLOR_W = 32;
    localparam int RAD_W   = 15;
    localparam int OFS_W   = COORD_BITS + 2;
    localparam int PT_W    = COORD_BITS + 3;
    localparam int DEC_W   = 20;
    localparam int PROD_W  = PIX_W + DIM_W;

    localparam int ALPHA_LSB = 24;
    localparam int ALPHA_W   = 8;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

    localparam int NUM_OCT = 8;
    localparam int OCT_W   = $clog2(NUM_OCT);
    localparam logic [OCT_W-1:0] OCT_LAST = OCT_W'(NUM_OCT - 1);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [DIM_W-1:0] FRAME_W_RESET = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_H_RESET = DIM_W'(480);
    localparam logic [DIM_W-1:0] FRAME_DIM_MAX = DIM_W'(MAX_FRAME_DIM);

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic                         is_null;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFS_W-1:0]      a;
        logic signed [OFS_W-1:0]      b;
        logic [COLOR_W-1:0]           color;
        logic                         done;
    } t_cmd;

    typedef struct packed {
        logic               visible;
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic               blend;
        logic               last;
        logic               done;
    } t_result;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        clamp_dim = (v > FRAME_DIM_MAX) ? FRAME_DIM_MAX : v;
    endfunction

endpackage

// ===== src/midpoint_circle_rasterizer_core.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_push / o_full    i_opcode, i_center_x, i_center_y, i_radius,
//                                         i_argb_color
// result    out        o_empty / i_pop    o_visible, o_pixel_x, o_pixel_y, o_pixel_address,
//                                         o_pixel_color, o_needs_blend, o_last_of_step,
//                                         o_circle_done
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// A start word yields no result; a step word yields eight result words at one per cycle,
// set by the octant sequencer while no unpopped result holds it back, or one word when
// no circle is open; each result passes stage 1 and stage 2 into the result register.
// A two-entry command queue sits between the walk front end and the octant sequencer,
// so input is taken while results wait; the result register holds until popped.
// Reset is synchronous and active low; frame size returns to 640 by 480.
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_center_y,
    input  logic [RAD_W-1:0]      i_radius,
    input  logic [COLOR_W-1:0]    i_argb_color,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_visible,
    output logic [PIX_W-1:0]      o_pixel_x,
    output logic [PIX_W-1:0]      o_pixel_y,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_needs_blend,
    output logic                  o_last_of_step,
    output logic                  o_circle_done,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [DIM_W-1:0]      i_cfg_data
);

    logic [DIM_W-1:0] r_frame_w;
    logic [DIM_W-1:0] r_frame_h;

    logic    q_full;
    logic    q_push;
    t_cmd    q_in;
    logic    q_valid;
    logic    q_pop;
    t_cmd    q_out;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_W_RESET;
            r_frame_h <= FRAME_H_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_frame_w <= clamp_dim(i_cfg_data);
                CFG_FRAME_HEIGHT: r_frame_h <= clamp_dim(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    mcr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_opcode     (i_opcode),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_argb_color (i_argb_color),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_cmd      (q_in)
    );

    mcr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .i_frame_w   (r_frame_w),
        .i_frame_h   (r_frame_h),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (res)
    );

    assign o_visible       = res.visible;
    assign o_pixel_x       = res.x;
    assign o_pixel_y       = res.y;
    assign o_pixel_address = res.address;
    assign o_pixel_color   = res.color;
    assign o_needs_blend   = res.blend;
    assign o_last_of_step  = res.last;
    assign o_circle_done   = res.done;

endmodule

// ===== src/mcr_front.sv =====
module mcr_front
    import mcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic                  i_opcode,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_center_y,
    input  logic [RAD_W-1:0]      i_radius,
    input  logic [COLOR_W-1:0]    i_argb_color,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_cmd                  o_q_cmd
);

    logic                         r_active;
    logic signed [COORD_BITS-1:0] r_cx;
    logic signed [COORD_BITS-1:0] r_cy;
    logic signed [OFS_W-1:0]      r_a;
    logic signed [OFS_W-1:0]      r_b;
    logic signed [DEC_W-1:0]      r_d;
    logic [COLOR_W-1:0]           r_color;

    logic                         n_active;
    logic signed [OFS_W-1:0]      n_a;
    logic signed [OFS_W-1:0]      n_b;
    logic signed [DEC_W-1:0]      n_d;
    logic signed [DEC_W-1:0]      a_ext;
    logic signed [DEC_W-1:0]      diff_ext;
    logic signed [OFS_W-1:0]      diff;
    logic                         accept;
    logic                         is_step;

    assign o_full  = i_q_full;
    assign accept  = i_push && !i_q_full;
    assign is_step = (t_opcode'(i_opcode) == OP_STEP);

    always_comb begin
        n_a      = r_a + OFS_W'(1);
        a_ext    = {{(DEC_W-OFS_W){n_a[OFS_W-1]}}, n_a};
        n_b      = r_b;
        diff     = '0;
        diff_ext = '0;
        if (r_d < 0) begin
            n_d = r_d + (a_ext <<< 1) + DEC_W'(1);
        end else begin
            n_b      = r_b - OFS_W'(1);
            diff     = n_a - n_b;
            diff_ext = {{(DEC_W-OFS_W){diff[OFS_W-1]}}, diff};
            n_d      = r_d + (diff_ext <<< 1) + DEC_W'(1);
        end
        n_active = !(n_b < n_a);
    end

    assign o_q_push        = accept && is_step;
    assign o_q_cmd.is_null = !r_active;
    assign o_q_cmd.cx      = r_cx;
    assign o_q_cmd.cy      = r_cy;
    assign o_q_cmd.a       = r_a;
    assign o_q_cmd.b       = r_b;
    assign o_q_cmd.color   = r_color;
    assign o_q_cmd.done    = !n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_d      <= '0;
            r_color  <= '0;
        end else if (accept) begin
            if (!is_step) begin
                r_active <= 1'b1;
                r_cx     <= i_center_x;
                r_cy     <= i_center_y;
                r_a      <= '0;
                r_b      <= OFS_W'(i_radius);
                r_d      <= DEC_W'(1) - DEC_W'(i_radius);
                r_color  <= i_argb_color;
            end else if (r_active) begin
                r_active <= n_active;
                r_a      <= n_a;
                r_b      <= n_b;
                r_d      <= n_d;
            end
        end
    end

endmodule

// ===== src/mcr_cmd_queue.sv =====
module mcr_cmd_queue
    import mcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wp;
    logic [CMDQ_PTR_W-1:0] r_rp;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("command queue count exceeds its depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH)) |-> (r_wp == r_rp))
        else $error("command queue pointers disagree with count");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !do_pop) |=> o_full)
        else $error("command queue lost fullness without a pop");

endmodule

// ===== src/mcr_back.sv =====
module mcr_back
    import mcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [DIM_W-1:0] i_frame_w,
    input  logic [DIM_W-1:0] i_frame_h,
    input  logic             i_pop,
    output logic             o_empty,
    output t_result          o_res
);

    t_cmd             r_cmd;
    logic             r_busy;
    logic [OCT_W-1:0] r_oct;

    logic                    r_s1_v;
    logic signed [PT_W-1:0]  r_s1_px;
    logic signed [PT_W-1:0]  r_s1_py;
    logic [COLOR_W-1:0]      r_s1_color;
    logic                    r_s1_null;
    logic                    r_s1_last;
    logic                    r_s1_done;

    logic                    r_s2_v;
    logic                    r_s2_vis;
    logic [PIX_W-1:0]        r_s2_x;
    logic [PIX_W-1:0]        r_s2_y;
    logic [ADDR_W-1:0]       r_s2_prod;
    logic [COLOR_W-1:0]      r_s2_color;
    logic                    r_s2_blend;
    logic                    r_s2_last;
    logic                    r_s2_done;

    logic                    r_out_v;
    t_result                 r_out;

    logic                    out_rdy;
    logic                    s2_rdy;
    logic                    s1_rdy;
    logic                    oct_last;
    logic                    take;
    logic signed [OFS_W-1:0] u;
    logic signed [OFS_W-1:0] v;
    logic signed [PT_W-1:0]  u_ext;
    logic signed [PT_W-1:0]  v_ext;
    logic signed [PT_W-1:0]  cx_ext;
    logic signed [PT_W-1:0]  cy_ext;
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
    logic [ALPHA_W-1:0]      alpha;
    logic                    vis;
    logic [PIX_W-1:0]        vx;
    logic [PIX_W-1:0]        vy;
    logic [PROD_W-1:0]       prod;

    assign out_rdy = !r_out_v || i_pop;
    assign s2_rdy  = !r_s2_v || out_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;

    assign oct_last  = r_cmd.is_null || (r_oct == OCT_LAST);
    assign take      = i_cmd_valid && (!r_busy || (s1_rdy && oct_last));
    assign o_cmd_pop = take;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oct  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_oct  <= '0;
        end else if (r_busy && s1_rdy) begin
            if (oct_last) begin
                r_busy <= 1'b0;
                r_oct  <= '0;
            end else begin
                r_oct <= r_oct + 1'b1;
            end
        end
    end

    // Octants 4..7 swap the two offsets; bit 0 negates the column term, bit 1 the row term.
    always_comb begin
        u      = r_oct[2] ? r_cmd.b : r_cmd.a;
        v      = r_oct[2] ? r_cmd.a : r_cmd.b;
        u_ext  = {{(PT_W-OFS_W){u[OFS_W-1]}}, u};
        v_ext  = {{(PT_W-OFS_W){v[OFS_W-1]}}, v};
        cx_ext = {{(PT_W-COORD_BITS){r_cmd.cx[COORD_BITS-1]}}, r_cmd.cx};
        cy_ext = {{(PT_W-COORD_BITS){r_cmd.cy[COORD_BITS-1]}}, r_cmd.cy};
        px     = r_oct[0] ? (cx_ext - u_ext) : (cx_ext + u_ext);
        py     = r_oct[1] ? (cy_ext - v_ext) : (cy_ext + v_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_v <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_px    <= px;
            r_s1_py    <= py;
            r_s1_color <= r_cmd.color;
            r_s1_null  <= r_cmd.is_null;
            r_s1_last  <= oct_last;
            r_s1_done  <= r_cmd.done && oct_last;
        end
    end

    always_comb begin
        alpha = r_s1_color[ALPHA_LSB +: ALPHA_W];
        vis   = !r_s1_null && (alpha != '0)
             && !r_s1_px[PT_W-1] && !r_s1_py[PT_W-1]
             && (r_s1_px[PT_W-2:0] < (PT_W-1)'(i_frame_w))
             && (r_s1_py[PT_W-2:0] < (PT_W-1)'(i_frame_h));
        vx    = vis ? r_s1_px[PIX_W-1:0] : '0;
        vy    = vis ? r_s1_py[PIX_W-1:0] : '0;
        prod  = vy * i_frame_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_vis   <= vis;
            r_s2_x     <= vx;
            r_s2_y     <= vy;
            r_s2_prod  <= prod[ADDR_W-1:0];
            r_s2_color <= vis ? r_s1_color : '0;
            r_s2_blend <= vis && (alpha != ALPHA_OPAQUE);
            r_s2_last  <= r_s1_null || r_s1_last;
            r_s2_done  <= r_s1_null || r_s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out.visible <= r_s2_vis;
            r_out.x       <= r_s2_x;
            r_out.y       <= r_s2_y;
            r_out.address <= r_s2_prod + ADDR_W'(r_s2_x);
            r_out.color   <= r_s2_color;
            r_out.blend   <= r_s2_blend;
            r_out.last    <= r_s2_last;
            r_out.done    <= r_s2_done;
        end
    end

    assign o_empty = !r_out_v;
    assign o_res   = r_out;

    a_oct_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_oct == '0))
        else $error("octant counter moved without a command");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.done) |-> r_out.last)
        else $error("completion flag on a word that does not close its step");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.visible) |->
        (r_out.address == '0 && r_out.color == '0 && !r_out.blend))
        else $error("hidden point carries pixel data");

    a_null_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cmd.is_null && s1_rdy) |=> (r_s1_v && r_s1_last))
        else $error("idle step did not produce a single closing word");

endmodule

// ===== test/tb_midpoint_circle_rasterizer_core.sv =====
`timescale 1ns / 100ps

module tb_midpoint_circle_rasterizer_core;
    import mcr_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_WAIT  = 12;
    localparam int RANDOM_WORDS = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    logic                  i_opcode;
    logic [COORD_BITS-1:0] i_center_x;
    logic [COORD_BITS-1:0] i_center_y;
    logic [RAD_W-1:0]      i_radius;
    logic [COLOR_W-1:0]    i_argb_color;
    logic                  o_empty;
    logic                  i_pop;
    logic                  o_visible;
    logic [PIX_W-1:0]      o_pixel_x;
    logic [PIX_W-1:0]      o_pixel_y;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic                  o_needs_blend;
    logic                  o_last_of_step;
    logic                  o_circle_done;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [DIM_W-1:0]      i_cfg_data;

    midpoint_circle_rasterizer_core u_top (.*);

    logic                         walk_on;
    logic signed [COORD_BITS-1:0] walk_cx;
    logic signed [COORD_BITS-1:0] walk_cy;
    logic signed [OFS_W-1:0]      walk_minor;
    logic signed [OFS_W-1:0]      walk_major;
    logic signed [DEC_W-1:0]      walk_decision;
    logic [COLOR_W-1:0]           walk_argb;
    logic [DIM_W-1:0]             frame_w;
    logic [DIM_W-1:0]             frame_h;

    t_result pending_points[$];
    bit      no_idle;
    int      words_sent;
    int      start_words;
    int      step_words;
    int      outlines_done;
    int      frame_settings;
    int      results_seen;
    int      visible_seen;
    int      blend_seen;
    int      bad_words;
    int      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_result plot_point(int px, int py);
        t_result            pt;
        logic [ALPHA_W-1:0] alpha;
        pt = '0;
        alpha = walk_argb[ALPHA_LSB +: ALPHA_W];
        if (px >= 0 && py >= 0 && px < int'(frame_w) && py < int'(frame_h) && alpha != '0) begin
            pt.visible = 1'b1;
            pt.x       = PIX_W'(px);
            pt.y       = PIX_W'(py);
            pt.address = ADDR_W'(py * int'(frame_w) + px);
            pt.color   = walk_argb;
            pt.blend   = (alpha != ALPHA_OPAQUE);
        end
        return pt;
    endfunction

    function automatic void predict_word(t_opcode op, logic [COORD_BITS-1:0] cx,
                                         logic [COORD_BITS-1:0] cy, logic [RAD_W-1:0] r,
                                         logic [COLOR_W-1:0] argb);
        t_result pt;
        int      ox, oy, a, b, d;
        if (op == OP_START) begin
            walk_on       = 1'b1;
            walk_cx       = cx;
            walk_cy       = cy;
            walk_minor    = '0;
            walk_major    = OFS_W'(r);
            walk_decision = DEC_W'(1 - int'(r));
            walk_argb     = argb;
            start_words++;
            return;
        end
        step_words++;
        if (!walk_on) begin
            pt      = '0;
            pt.last = 1'b1;
            pt.done = 1'b1;
            pending_points.push_back(pt);
            return;
        end
        ox = walk_cx;
        oy = walk_cy;
        a  = walk_minor;
        b  = walk_major;
        d  = walk_decision;
        pending_points.push_back(plot_point(ox + a, oy + b));
        pending_points.push_back(plot_point(ox - a, oy + b));
        pending_points.push_back(plot_point(ox + a, oy - b));
        pending_points.push_back(plot_point(ox - a, oy - b));
        pending_points.push_back(plot_point(ox + b, oy + a));
        pending_points.push_back(plot_point(ox - b, oy + a));
        pending_points.push_back(plot_point(ox + b, oy - a));
        pt = plot_point(ox - b, oy - a);
        a++;
        if (d < 0) begin
            d += 2 * a + 1;
        end else begin
            b--;
            d += 2 * (a - b) + 1;
        end
        walk_minor    = OFS_W'(a);
        walk_major    = OFS_W'(b);
        walk_decision = DEC_W'(d);
        walk_on       = !(b < a);
        pt.last       = 1'b1;
        pt.done       = (b < a);
        if (b < a) outlines_done++;
        pending_points.push_back(pt);
    endfunction

    function automatic void report_word(string what, t_result want, t_result got);
        bad_words++;
        if (bad_words <= 10) begin
            $display("%0t %s (expected/actual): vis %b/%b x %0d/%0d y %0d/%0d", $time, what,
                     want.visible, got.visible, want.x, got.x, want.y, got.y);
            $display("    addr %h/%h color %h/%h blend %b/%b last %b/%b done %b/%b",
                     want.address, got.address, want.color, got.color, want.blend, got.blend,
                     want.last, got.last, want.done, got.done);
        end
    endfunction

    function automatic logic [COLOR_W-1:0] pick_argb();
        logic [COLOR_W-1:0] argb;
        argb = $urandom;
        case ($urandom_range(0, 3))
            0: argb[ALPHA_LSB +: ALPHA_W] = '0;
            1: argb[ALPHA_LSB +: ALPHA_W] = ALPHA_OPAQUE;
            2: argb[ALPHA_LSB +: ALPHA_W] = ALPHA_W'($urandom_range(1, 254));
            default: ;
        endcase
        return argb;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (i_pop && !o_empty) begin
                got = {o_visible, o_pixel_x, o_pixel_y, o_pixel_address, o_pixel_color,
                       o_needs_blend, o_last_of_step, o_circle_done};
                results_seen++;
                if (got.visible) visible_seen++;
                if (got.blend) blend_seen++;
                if (pending_points.size() == 0) begin
                    report_word("word with none expected", '0, got);
                end else begin
                    want = pending_points.pop_front();
                    if (got !== want) report_word("word mismatch", want, got);
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : result_drain
        int stall;
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                @(negedge i_clk);
                i_pop <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    task automatic send_word(t_opcode op, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [RAD_W-1:0] r, logic [COLOR_W-1:0] argb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_push       <= 1'b1;
        i_opcode     <= op;
        i_center_x   <= cx;
        i_center_y   <= cy;
        i_radius     <= r;
        i_argb_color <= argb;
        do @(posedge i_clk); while (o_full);
        predict_word(op, cx, cy, r, argb);
        words_sent++;
    endtask

    task automatic send_step();
        send_word(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'($urandom),
                  $urandom);
    endtask

    task automatic run_circle(int cx, int cy, int r, logic [COLOR_W-1:0] argb, int max_steps);
        int n;
        n = 0;
        send_word(OP_START, COORD_BITS'(cx), COORD_BITS'(cy), RAD_W'(r), argb);
        while (walk_on && n < max_steps) begin
            send_step();
            n++;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DIM_W-1:0] value);
        logic [DIM_W-1:0] held;
        held = (value > FRAME_DIM_MAX) ? FRAME_DIM_MAX : value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) frame_w = held;
        else frame_h = held;
    endtask

    task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        frame_settings++;
    endtask

    task automatic random_sequence();
        int r, cx, cy;
        no_idle = ($urandom_range(0, 3) == 0);
        r  = $urandom_range(0, 24);
        cx = $urandom_range(0, int'(frame_w) + 2 * r + 8) - r - 4;
        cy = $urandom_range(0, int'(frame_h) + 2 * r + 8) - r - 4;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                run_circle(cx, cy, r, pick_argb(), 1000);
                if ($urandom_range(0, 3) == 0) send_step();
            end
            6: run_circle($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 4));
            7: send_step();
            8: begin
                send_word(OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          RAD_W'($urandom), $urandom);
                run_circle(cx, cy, r, pick_argb(), 1000);
            end
            default: run_circle(cx, cy, r, pick_argb(), $urandom_range(0, 3));
        endcase
    endtask

    task automatic test_step_without_circle();
        send_step();
        send_step();
    endtask

    task automatic test_zero_radius();
        run_circle(10, 10, 0, 32'hFF10_2030, 1000);
        send_step();
    endtask

    task automatic test_field_extremes();
        run_circle(-32768, 32767, 32767, 32'hFFFF_FFFF, 2);
        run_circle(32767, -32768, 0, 32'h0000_0000, 1);
    endtask

    task automatic test_alpha_levels();
        no_idle = 1'b1;
        run_circle(0, 0, 3, 32'hFF12_3456, 1000);
        no_idle = 1'b0;
        run_circle(639, 479, 2, 32'h01AB_CDEF, 1000);
        run_circle(320, 240, 4, 32'hFE55_AA55, 1000);
    endtask

    task automatic test_frame_limits();
        set_frame(13'd1, 13'd1);
        run_circle(0, 0, 0, 32'hFF00_00FF, 1000);
        set_frame(13'd0, 13'd0);
        run_circle(0, 0, 1, 32'hFF00_FF00, 1000);
        set_frame(13'h1FFF, 13'd4096);
        run_circle(4095, 4095, 0, 32'h80FE_DCBA, 1000);
        set_frame(13'd4096, 13'h1FFF);
        run_circle(4093, 4090, 3, 32'hFFC0_FFEE, 1000);
    endtask

    task automatic test_random_walks(int words);
        int target;
        target = words_sent + words;
        while (words_sent < target) random_sequence();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_opcode      = OP_STEP;
        i_center_x    = '0;
        i_center_y    = '0;
        i_radius      = '0;
        i_argb_color  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_FRAME_WIDTH;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        walk_on       = 1'b0;
        walk_cx       = '0;
        walk_cy       = '0;
        walk_minor    = '0;
        walk_major    = '0;
        walk_decision = '0;
        walk_argb     = '0;
        frame_w       = FRAME_W_RESET;
        frame_h       = FRAME_H_RESET;
        frame_settings = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_step_without_circle();
        test_zero_radius();
        test_field_extremes();
        test_alpha_levels();
        test_frame_limits();

        set_frame(13'd640, 13'd480);
        test_random_walks(RANDOM_WORDS * 2 / 5);
        set_frame(DIM_W'($urandom_range(1, 200)), DIM_W'($urandom_range(1, 200)));
        test_random_walks(RANDOM_WORDS * 3 / 10);
        set_frame(DIM_W'($urandom), DIM_W'($urandom));
        test_random_walks(RANDOM_WORDS * 3 / 10);

        wait_drained();
        if (pending_points.size() != 0)
            $display("%0d expected words never arrived.", pending_points.size());
        $display("Sent %0d words (%0d starts, %0d steps) over %0d frame settings.",
                 words_sent, start_words, step_words, frame_settings);
        $display("Checked %0d result words: %0d visible, %0d to blend, %0d outlines done, %0d bad.",
                 results_seen, visible_seen, blend_seen, outlines_done, bad_words);
        if (bad_words == 0 && pending_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
